// ===== src/triple_sha256_header_check_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the triple SHA-256 header check unit
// Shared property forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef TRIPLE_SHA256_HEADER_CHECK_UNIT_ASSERT_SVH
`define TRIPLE_SHA256_HEADER_CHECK_UNIT_ASSERT_SVH

// same-cycle implication
`define TSHC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tshc check failed");

// next-cycle implication
`define TSHC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tshc check failed");

`endif

// ===== src/tshc_pkg.sv =====
// ----------------------------------------------------------------------------
// tshc_pkg
// Types, constants and SHA-256 helper functions for the header check unit.
// ----------------------------------------------------------------------------
package tshc_pkg;

    typedef logic [31:0] word_t;
    typedef word_t [7:0] state_t;
    typedef word_t [15:0] win_t;

    localparam int unsigned ROUNDS = 64;

    localparam word_t PAD_WORD = 32'h8000_0000;
    localparam word_t LEN_HDR  = 32'd640;
    localparam word_t LEN_DIG  = 32'd256;

    localparam logic [2:0] CFG_TGT_76 = 3'd0;
    localparam logic [2:0] CFG_TGT_54 = 3'd1;
    localparam logic [2:0] CFG_TGT_32 = 3'd2;
    localparam logic [2:0] CFG_TGT_10 = 3'd3;
    localparam logic [2:0] CFG_SUPP   = 3'd4;

    localparam state_t IV = '{32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
                              32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667};

    localparam word_t [0:63] K = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic word_t big_s0(word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_s1(word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t sml_s0(word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t sml_s1(word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    function automatic word_t bswap(word_t x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

endpackage

// ===== src/tshc_round_cell.sv =====
// ----------------------------------------------------------------------------
// tshc_round_cell
// One SHA-256 round with its message schedule step, registered.
// ----------------------------------------------------------------------------
module tshc_round_cell #(
    parameter int unsigned ROUND  = 0,
    parameter int unsigned SIDE_W = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  tshc_pkg::state_t    in_state,
    input  tshc_pkg::win_t      in_win,
    input  tshc_pkg::state_t    in_base,
    input  logic [SIDE_W-1:0]   in_side,
    output logic                out_valid,
    output tshc_pkg::state_t    out_state,
    output tshc_pkg::win_t      out_win,
    output tshc_pkg::state_t    out_base,
    output logic [SIDE_W-1:0]   out_side
);

    localparam tshc_pkg::word_t RK = tshc_pkg::K[ROUND];

    logic               valid_reg;
    tshc_pkg::state_t   state_reg, state_next;
    tshc_pkg::win_t     win_reg, win_next;
    tshc_pkg::state_t   base_reg;
    logic [SIDE_W-1:0]  side_reg;
    tshc_pkg::word_t    t1, t2, ch, maj;

    always_comb begin
        ch  = (in_state[4] & in_state[5]) ^ (~in_state[4] & in_state[6]);
        maj = (in_state[0] & in_state[1]) ^ (in_state[0] & in_state[2])
            ^ (in_state[1] & in_state[2]);
        t1  = in_state[7] + tshc_pkg::big_s1(in_state[4]) + ch + RK + in_win[0];
        t2  = tshc_pkg::big_s0(in_state[0]) + maj;
        state_next[0] = t1 + t2;
        state_next[1] = in_state[0];
        state_next[2] = in_state[1];
        state_next[3] = in_state[2];
        state_next[4] = in_state[3] + t1;
        state_next[5] = in_state[4];
        state_next[6] = in_state[5];
        state_next[7] = in_state[6];
        for (int i = 0; i < 15; i++) begin
            win_next[i] = in_win[i+1];
        end
        win_next[15] = in_win[0] + tshc_pkg::sml_s0(in_win[1]) + in_win[9]
                     + tshc_pkg::sml_s1(in_win[14]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            state_reg <= state_next;
            win_reg   <= win_next;
            base_reg  <= in_base;
            side_reg  <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;
    assign out_win   = win_reg;
    assign out_base  = base_reg;
    assign out_side  = side_reg;

endmodule

// ===== src/tshc_compress.sv =====
// ----------------------------------------------------------------------------
// tshc_compress
// Chain of 64 round cells and a registered feed-forward add.
// ----------------------------------------------------------------------------
module tshc_compress #(
    parameter int unsigned SIDE_W = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  tshc_pkg::win_t      in_msg,
    input  tshc_pkg::state_t    in_base,
    input  logic [SIDE_W-1:0]   in_side,
    output logic                out_valid,
    output tshc_pkg::state_t    out_digest,
    output logic [SIDE_W-1:0]   out_side
);

    localparam int unsigned N = tshc_pkg::ROUNDS;

    logic               vld   [N+1];
    tshc_pkg::state_t   st    [N+1];
    tshc_pkg::win_t     win   [N+1];
    tshc_pkg::state_t   base  [N+1];
    logic [SIDE_W-1:0]  side  [N+1];

    logic               valid_reg;
    tshc_pkg::state_t   digest_reg;
    logic [SIDE_W-1:0]  side_reg;

    assign vld[0]  = in_valid;
    assign st[0]   = in_base;
    assign win[0]  = in_msg;
    assign base[0] = in_base;
    assign side[0] = in_side;

    for (genvar r = 0; r < N; r++) begin : g_round
        tshc_round_cell #(.ROUND(r), .SIDE_W(SIDE_W)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (vld[r]),
            .in_state  (st[r]),
            .in_win    (win[r]),
            .in_base   (base[r]),
            .in_side   (side[r]),
            .out_valid (vld[r+1]),
            .out_state (st[r+1]),
            .out_win   (win[r+1]),
            .out_base  (base[r+1]),
            .out_side  (side[r+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= vld[N];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 8; i++) begin
                digest_reg[i] <= base[N][i] + st[N][i];
            end
            side_reg <= side[N];
        end
    end

    assign out_valid  = valid_reg;
    assign out_digest = digest_reg;
    assign out_side   = side_reg;

endmodule

// ===== src/triple_sha256_header_check_unit.sv =====
// ----------------------------------------------------------------------------
// triple_sha256_header_check_unit
// Triple SHA-256 of an 80-byte header with target compare.
// ----------------------------------------------------------------------------
// The unit takes one header request per clock while s_ready is high and
// returns one result per request, in order: four SHA-256 compressions
// in a row, each a chain of 64 round cells plus one feed-forward register,
// then the output register with byte swap and the 256-bit target compare.
// The whole pipeline holds only when its last stage and the output register
// are both full and m_ready is low. Target and suppress registers must be
// written through the cfg port while no request is in flight (not enforced).
module triple_sha256_header_check_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [63:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_header_w0_w1,
    input  logic [63:0] s_header_w2_w3,
    input  logic [63:0] s_header_w4_w5,
    input  logic [63:0] s_header_w6_w7,
    input  logic [63:0] s_header_w8_w9,
    input  logic [63:0] s_header_w10_w11,
    input  logic [63:0] s_header_w12_w13,
    input  logic [63:0] s_header_w14_w15,
    input  logic [63:0] s_header_w16_w17,
    input  logic [31:0] s_header_w18,
    input  logic [31:0] s_nonce,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_hit,
    output logic [63:0] m_hash_w7_w6,
    output logic [63:0] m_hash_w5_w4,
    output logic [63:0] m_hash_w3_w2,
    output logic [63:0] m_hash_w1_w0,
    output logic [31:0] m_nonce_echo
);

    logic [63:0]        tgt_reg [4];
    logic               supp_reg;
    logic               adv;
    logic               out_load;

    tshc_pkg::win_t     msg1, msg2, msg3, msg4;
    logic [127:0]       side1;
    logic               v1, v2, v3, v4;
    tshc_pkg::state_t   d1, d2, d3, d4;
    logic [127:0]       s1o;
    logic [31:0]        s2o, s3o, s4o;

    logic [255:0]       hash_cat, tgt_cat;
    logic               m_valid_reg;
    logic               hit_reg;
    logic [255:0]       hash_reg;
    logic [31:0]        nonce_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tgt_reg[0] <= '0;
            tgt_reg[1] <= '0;
            tgt_reg[2] <= '0;
            tgt_reg[3] <= '0;
            supp_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                tshc_pkg::CFG_TGT_76: tgt_reg[0] <= cfg_wdata;
                tshc_pkg::CFG_TGT_54: tgt_reg[1] <= cfg_wdata;
                tshc_pkg::CFG_TGT_32: tgt_reg[2] <= cfg_wdata;
                tshc_pkg::CFG_TGT_10: tgt_reg[3] <= cfg_wdata;
                tshc_pkg::CFG_SUPP:   supp_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign adv      = !(v4 && m_valid_reg && !m_ready);
    assign out_load = !m_valid_reg || m_ready;
    assign s_ready  = adv;

    always_comb begin
        msg1 = {s_header_w14_w15[31:0], s_header_w14_w15[63:32],
                s_header_w12_w13[31:0], s_header_w12_w13[63:32],
                s_header_w10_w11[31:0], s_header_w10_w11[63:32],
                s_header_w8_w9[31:0],   s_header_w8_w9[63:32],
                s_header_w6_w7[31:0],   s_header_w6_w7[63:32],
                s_header_w4_w5[31:0],   s_header_w4_w5[63:32],
                s_header_w2_w3[31:0],   s_header_w2_w3[63:32],
                s_header_w0_w1[31:0],   s_header_w0_w1[63:32]};
        side1 = {s_header_w16_w17, s_header_w18, s_nonce};

        msg2     = '0;
        msg2[0]  = s1o[127:96];
        msg2[1]  = s1o[95:64];
        msg2[2]  = s1o[63:32];
        msg2[3]  = s1o[31:0];
        msg2[4]  = tshc_pkg::PAD_WORD;
        msg2[15] = tshc_pkg::LEN_HDR;

        msg3 = '0;
        msg4 = '0;
        for (int i = 0; i < 8; i++) begin
            msg3[i] = d2[i];
            msg4[i] = d3[i];
        end
        msg3[8]  = tshc_pkg::PAD_WORD;
        msg3[15] = tshc_pkg::LEN_DIG;
        msg4[8]  = tshc_pkg::PAD_WORD;
        msg4[15] = tshc_pkg::LEN_DIG;
    end

    tshc_compress #(.SIDE_W(128)) u_blk1 (
        .aclk(aclk), .aresetn(aresetn), .en(adv),
        .in_valid(s_valid), .in_msg(msg1), .in_base(tshc_pkg::IV), .in_side(side1),
        .out_valid(v1), .out_digest(d1), .out_side(s1o)
    );

    tshc_compress #(.SIDE_W(32)) u_blk2 (
        .aclk(aclk), .aresetn(aresetn), .en(adv),
        .in_valid(v1), .in_msg(msg2), .in_base(d1), .in_side(s1o[31:0]),
        .out_valid(v2), .out_digest(d2), .out_side(s2o)
    );

    tshc_compress #(.SIDE_W(32)) u_rh1 (
        .aclk(aclk), .aresetn(aresetn), .en(adv),
        .in_valid(v2), .in_msg(msg3), .in_base(tshc_pkg::IV), .in_side(s2o),
        .out_valid(v3), .out_digest(d3), .out_side(s3o)
    );

    tshc_compress #(.SIDE_W(32)) u_rh2 (
        .aclk(aclk), .aresetn(aresetn), .en(adv),
        .in_valid(v3), .in_msg(msg4), .in_base(tshc_pkg::IV), .in_side(s3o),
        .out_valid(v4), .out_digest(d4), .out_side(s4o)
    );

    always_comb begin
        hash_cat = {tshc_pkg::bswap(d4[7]), tshc_pkg::bswap(d4[6]),
                    tshc_pkg::bswap(d4[5]), tshc_pkg::bswap(d4[4]),
                    tshc_pkg::bswap(d4[3]), tshc_pkg::bswap(d4[2]),
                    tshc_pkg::bswap(d4[1]), tshc_pkg::bswap(d4[0])};
        tgt_cat  = {tgt_reg[0], tgt_reg[1], tgt_reg[2], tgt_reg[3]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= v4;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            hash_reg  <= hash_cat;
            hit_reg   <= (hash_cat <= tgt_cat) && !supp_reg;
            nonce_reg <= s4o;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_hit        = hit_reg;
    assign m_hash_w7_w6 = hash_reg[255:192];
    assign m_hash_w5_w4 = hash_reg[191:128];
    assign m_hash_w3_w2 = hash_reg[127:64];
    assign m_hash_w1_w0 = hash_reg[63:0];
    assign m_nonce_echo = nonce_reg;

endmodule

// ===== src/tshc_checker.sv =====
// ----------------------------------------------------------------------------
// tshc_checker
// Port-level checks for the header check unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "triple_sha256_header_check_unit_assert.svh"

module tshc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        cfg_wr_en,
    input logic [2:0]  cfg_addr,
    input logic [63:0] cfg_wdata,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_hit,
    input logic [63:0] m_hash_w7_w6,
    input logic [63:0] m_hash_w5_w4,
    input logic [63:0] m_hash_w3_w2,
    input logic [63:0] m_hash_w1_w0,
    input logic [31:0] m_nonce_echo
);

    logic [255:0] tgt_reg;
    logic         supp_reg;
    logic [255:0] hash_cat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tgt_reg  <= '0;
            supp_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                tshc_pkg::CFG_TGT_76: tgt_reg[255:192] <= cfg_wdata;
                tshc_pkg::CFG_TGT_54: tgt_reg[191:128] <= cfg_wdata;
                tshc_pkg::CFG_TGT_32: tgt_reg[127:64]  <= cfg_wdata;
                tshc_pkg::CFG_TGT_10: tgt_reg[63:0]    <= cfg_wdata;
                tshc_pkg::CFG_SUPP:   supp_reg         <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign hash_cat = {m_hash_w7_w6, m_hash_w5_w4, m_hash_w3_w2, m_hash_w1_w0};

    `TSHC_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_nonce_echo))
    `TSHC_ASSERT_NOW(a_ready_no_result, !m_valid, s_ready)
    `TSHC_ASSERT_NOW(a_hit_not_supp, m_valid && m_hit, !supp_reg)
    `TSHC_ASSERT_NOW(a_hit_below_tgt, m_valid && m_hit, hash_cat <= tgt_reg)

endmodule

bind triple_sha256_header_check_unit tshc_checker u_tshc_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_hit        (m_hit),
    .m_hash_w7_w6 (m_hash_w7_w6),
    .m_hash_w5_w4 (m_hash_w5_w4),
    .m_hash_w3_w2 (m_hash_w3_w2),
    .m_hash_w1_w0 (m_hash_w1_w0),
    .m_nonce_echo (m_nonce_echo)
);

// ===== tb/tb_triple_sha256_header_check_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_triple_sha256_header_check_unit
// Self-checking bench for the triple SHA-256 header check unit.
// ----------------------------------------------------------------------------
// Header requests go in through a queued driver. An internal SHA-256 model
// computes the expected digest, hit flag and nonce echo for each request.
// The monitor compares every result against the oldest expected one. Target
// and suppress registers are rewritten between phases once the unit drains.
// Phases vary the idle rates on both sides.
module tb_triple_sha256_header_check_unit;

    localparam int LATENCY   = 261;
    localparam int WDOG_MAX  = 20000;

    typedef struct packed {
        logic [63:0] w01, w23, w45, w67, w89, w1011, w1213, w1415, w1617;
        logic [31:0] w18;
        logic [31:0] nonce;
    } hdr_req_t;

    typedef struct packed {
        logic        hit;
        logic [63:0] h76, h54, h32, h10;
        logic [31:0] nonce;
    } chk_res_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [2:0]  cfg_addr;
    logic [63:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic        s_ready_q;
    hdr_req_t    s_req;
    logic        m_valid;
    logic        m_ready;
    logic        m_hit;
    logic [63:0] m_hash_w7_w6, m_hash_w5_w4, m_hash_w3_w2, m_hash_w1_w0;
    logic [31:0] m_nonce_echo;

    hdr_req_t    pending_reqs[$];
    chk_res_t    expected_results[$];
    logic [63:0] target_reg[4];
    logic        suppress_reg;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          wdog;
    bit          failed;

    triple_sha256_header_check_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_header_w0_w1(s_req.w01), .s_header_w2_w3(s_req.w23),
        .s_header_w4_w5(s_req.w45), .s_header_w6_w7(s_req.w67),
        .s_header_w8_w9(s_req.w89), .s_header_w10_w11(s_req.w1011),
        .s_header_w12_w13(s_req.w1213), .s_header_w14_w15(s_req.w1415),
        .s_header_w16_w17(s_req.w1617), .s_header_w18(s_req.w18),
        .s_nonce(s_req.nonce),
        .m_valid(m_valid), .m_ready(m_ready), .m_hit(m_hit),
        .m_hash_w7_w6(m_hash_w7_w6), .m_hash_w5_w4(m_hash_w5_w4),
        .m_hash_w3_w2(m_hash_w3_w2), .m_hash_w1_w0(m_hash_w1_w0),
        .m_nonce_echo(m_nonce_echo)
    );

    function automatic tshc_pkg::word_t rotr(tshc_pkg::word_t x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic tshc_pkg::state_t sha_compress(tshc_pkg::win_t msg,
                                                      tshc_pkg::state_t st);
        tshc_pkg::word_t w[64];
        tshc_pkg::word_t v[8];
        tshc_pkg::word_t t1, t2, s0, s1;
        tshc_pkg::state_t res;
        for (int i = 0; i < 16; i++) w[i] = msg[i];
        for (int i = 16; i < 64; i++) begin
            s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        for (int i = 0; i < 8; i++) v[i] = st[i];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                + ((v[4] & v[5]) ^ (~v[4] & v[6])) + tshc_pkg::K[i] + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) res[i] = st[i] + v[i];
        return res;
    endfunction

    function automatic tshc_pkg::state_t digest_rehash(tshc_pkg::state_t d);
        tshc_pkg::win_t m;
        for (int i = 0; i < 16; i++) m[i] = '0;
        for (int i = 0; i < 8; i++) m[i] = d[i];
        m[8] = tshc_pkg::PAD_WORD;
        m[15] = tshc_pkg::LEN_DIG;
        return sha_compress(m, tshc_pkg::IV);
    endfunction

    function automatic chk_res_t header_hash(hdr_req_t r);
        logic [63:0] pairs[9];
        tshc_pkg::word_t hdr[20];
        tshc_pkg::win_t m;
        tshc_pkg::state_t mid, d;
        logic [255:0] hval, tval;
        chk_res_t res;
        pairs = '{r.w01, r.w23, r.w45, r.w67, r.w89, r.w1011, r.w1213, r.w1415, r.w1617};
        for (int i = 0; i < 9; i++) begin
            hdr[2*i] = pairs[i][63:32];
            hdr[2*i+1] = pairs[i][31:0];
        end
        hdr[18] = r.w18;
        hdr[19] = r.nonce;
        for (int i = 0; i < 16; i++) m[i] = hdr[i];
        mid = sha_compress(m, tshc_pkg::IV);
        for (int i = 0; i < 16; i++) m[i] = '0;
        for (int i = 0; i < 4; i++) m[i] = hdr[16+i];
        m[4] = tshc_pkg::PAD_WORD;
        m[15] = tshc_pkg::LEN_HDR;
        d = digest_rehash(digest_rehash(sha_compress(m, mid)));
        for (int i = 0; i < 8; i++)
            hval[32*i +: 32] = {d[i][7:0], d[i][15:8], d[i][23:16], d[i][31:24]};
        tval = {target_reg[0], target_reg[1], target_reg[2], target_reg[3]};
        res.hit = (hval <= tval) && !suppress_reg;
        res.h76 = hval[255:192];
        res.h54 = hval[191:128];
        res.h32 = hval[127:64];
        res.h10 = hval[63:0];
        res.nonce = r.nonce;
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic hdr_req_t rand_req();
        hdr_req_t r;
        r = {rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
             rand64(), rand64(), rand64(), $urandom, $urandom};
        return r;
    endfunction

    task automatic queue_req(hdr_req_t r);
        pending_reqs.push_back(r);
        expected_results.push_back(header_hash(r));
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [63:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx < tshc_pkg::CFG_SUPP)
            target_reg[idx[1:0]] = val;
        else if (idx == tshc_pkg::CFG_SUPP)
            suppress_reg = val[0];
    endtask

    task automatic set_target(logic [255:0] t, logic supp);
        cfg_write(tshc_pkg::CFG_TGT_76, t[255:192]);
        cfg_write(tshc_pkg::CFG_TGT_54, t[191:128]);
        cfg_write(tshc_pkg::CFG_TGT_32, t[127:64]);
        cfg_write(tshc_pkg::CFG_TGT_10, t[63:0]);
        cfg_write(tshc_pkg::CFG_SUPP, {63'd0, supp});
    endtask

    task automatic drain();
        wait (pending_reqs.size() == 0 && expected_results.size() == 0);
        repeat (LATENCY + 10) @(negedge aclk);
    endtask

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready_q) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_req <= pending_reqs.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) s_ready_q <= s_valid && s_ready;

    // monitor and watchdog
    always @(posedge aclk) begin
        chk_res_t exp_r, got_r;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                wdog <= 0;
            else
                wdog <= wdog + 1;
            if (wdog >= WDOG_MAX) begin
                $display("Some tests failed");
                $finish;
            end
            if (m_valid && m_ready) begin
                got_r = {m_hit, m_hash_w7_w6, m_hash_w5_w4, m_hash_w3_w2,
                         m_hash_w1_w0, m_nonce_echo};
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, actual %h", $realtime, got_r);
                    failed = 1'b1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got_r.hit !== exp_r.hit)
                        $display("%0t: hit expected %b actual %b", $realtime,
                                 exp_r.hit, got_r.hit);
                    if (got_r.h76 !== exp_r.h76)
                        $display("%0t: hash_w7_w6 expected %h actual %h", $realtime,
                                 exp_r.h76, got_r.h76);
                    if (got_r.h54 !== exp_r.h54)
                        $display("%0t: hash_w5_w4 expected %h actual %h", $realtime,
                                 exp_r.h54, got_r.h54);
                    if (got_r.h32 !== exp_r.h32)
                        $display("%0t: hash_w3_w2 expected %h actual %h", $realtime,
                                 exp_r.h32, got_r.h32);
                    if (got_r.h10 !== exp_r.h10)
                        $display("%0t: hash_w1_w0 expected %h actual %h", $realtime,
                                 exp_r.h10, got_r.h10);
                    if (got_r.nonce !== exp_r.nonce)
                        $display("%0t: nonce_echo expected %h actual %h", $realtime,
                                 exp_r.nonce, got_r.nonce);
                    if (got_r !== exp_r)
                        failed = 1'b1;
                end
            end
        end
    end

    initial begin
        hdr_req_t r;
        chk_res_t probe;
        logic [255:0] hv;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_req = '0;
        m_ready = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        wdog = 0;
        failed = 1'b0;
        for (int i = 0; i < 4; i++) target_reg[i] = '0;
        suppress_reg = 1'b0;
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        // directed: reset target, field extremes
        queue_req('0);
        queue_req('1);
        r = '0; r.nonce = '1; queue_req(r);
        r = '1; r.nonce = '0; queue_req(r);
        r = {{9{64'haaaa_aaaa_5555_5555}}, 32'h5555_aaaa, 32'haaaa_5555};
        queue_req(r);
        drain();

        // target at maximum: every hash hits
        set_target('1, 1'b0);
        for (int i = 0; i < 4; i++) queue_req(rand_req());
        drain();

        // target equal to a known hash, then one below it
        r = rand_req();
        probe = header_hash(r);
        hv = {probe.h76, probe.h54, probe.h32, probe.h10};
        set_target(hv, 1'b0);
        queue_req(r);
        drain();
        set_target(hv - 256'd1, 1'b0);
        queue_req(r);
        drain();

        // suppressed reporting with a full target; writes to unknown indices
        set_target('1, 1'b1);
        cfg_write(3'd5, '1);
        cfg_write(3'd7, '1);
        for (int i = 0; i < 4; i++) queue_req(rand_req());
        drain();

        // random phases with varying targets and idle rates
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 86 : 0;
            recv_idle_pct = (ph == 0) ? 86 : (ph == 1) ? 33 : 0;
            for (int blk = 0; blk < 3; blk++) begin
                case ($urandom_range(3))
                    0: set_target({8'h00, {31{8'hff}}} >> $urandom_range(8), 1'b0);
                    1: set_target({rand64(), rand64(), rand64(), rand64()}, 1'b0);
                    2: set_target('0, 1'($urandom_range(1)));
                    default: set_target('1, 1'($urandom_range(1)));
                endcase
                for (int i = 0; i < 78; i++) queue_req(rand_req());
                drain();
            end
        end

        if (!failed) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
